@@ rtl/core/afp_pkg.sv @@
package afp_pkg;

	localparam int unsigned LEN_DIGITS   = 2;
	localparam int unsigned CHECK_DIGITS = 2;

	localparam logic [7:0] CH_START = 8'h7E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FUNC,
		PH_LEN,
		PH_DATA,
		PH_CHECK,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOSTART  = 3'd1,
		ST_CHECKSUM = 3'd2,
		ST_NOSTOP   = 3'd3,
		ST_BADLEN   = 3'd4
	} status_t;

	// accumulator controls from the sequencer
	typedef struct packed {
		logic clear;
		logic data_en;
		logic check_en;
	} acc_ctl_t;

	// result request from the sequencer
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    zero_meta;
		logic    zero_data;
	} emit_t;

endpackage

@@ rtl/core/ascii_frame_parser.sv @@
// A transferred byte is parsed from the input register; a status it causes
// is registered in the result register and presented until taken.
// Throughput: one byte per cycle unless a status waits under out_stall; the
// input and result registers let a new byte enter while a status waits.
// Reset (arst_n low, asynchronous): parser idle awaiting '~', both registers empty.
module ascii_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] func_code,
	output logic [6:0]  data_length,
	output logic [31:0] data_value,
	output logic [31:0] sum_computed
);
	import afp_pkg::*;

	// input register stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	// result register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] func_out_q;
	logic [6:0]  length_out_q;
	logic [31:0] value_out_q;
	logic [31:0] sum_out_q;

	logic        advance;
	logic        step;
	acc_ctl_t    acc_ctl;
	emit_t       emit;
	logic [15:0] func_q;
	logic [6:0]  length_q;
	logic [31:0] value_acc;
	logic [31:0] sum_acc;
	logic        mismatch;

	// The stage-1 byte may move on whenever the result register is free or
	// being drained this cycle; bytes that give no status move on the same way.
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte while stalled; load on every transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	afp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (byte_s1),
		.mismatch (mismatch),
		.acc_ctl  (acc_ctl),
		.emit     (emit),
		.func_q   (func_q),
		.length_q (length_q)
	);

	afp_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (byte_s1),
		.ctl       (acc_ctl),
		.value_acc (value_acc),
		.sum_acc   (sum_acc),
		.mismatch  (mismatch)
	);

	// result valid: set on a parsed status, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload; no-start clears the frame fields, bad length the data fields
	always_ff @(posedge clk) begin
		if (step && emit.valid) begin
			status_q     <= emit.status;
			func_out_q   <= emit.zero_meta ? 16'd0 : func_q;
			length_out_q <= emit.zero_meta ? 7'd0 : length_q;
			value_out_q  <= emit.zero_data ? 32'd0 : value_acc;
			sum_out_q    <= emit.zero_data ? 32'd0 : sum_acc;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign func_code    = func_out_q;
	assign data_length  = length_out_q;
	assign data_value   = value_out_q;
	assign sum_computed = sum_out_q;

	// a parsed status always lands in the result register
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit.valid |=> out_valid)
		else $error("parsed status not presented");

	// stage 1 only pushes back while it holds a byte
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	// a no-start status carries no frame contents
	a_nostart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOSTART |->
		func_code == 16'd0 && data_length == 7'd0 && data_value == 32'd0
		&& sum_computed == 32'd0)
		else $error("no-start status with frame fields");

endmodule

@@ rtl/core/afp_acc.sv @@
module afp_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         rx_byte,
	input  afp_pkg::acc_ctl_t  ctl,
	output logic [31:0]        value_acc,
	output logic [31:0]        sum_acc,
	output logic               mismatch
);
	import afp_pkg::*;

	logic [31:0] value_q;
	logic [31:0] sum_q;
	logic [31:0] chk_q;
	logic [31:0] digit;
	logic [31:0] value_next;
	logic [31:0] chk_next;

	// digit value wraps modulo 2^32 for bytes below '0'
	assign digit      = {24'd0, rx_byte} - {24'd0, CH_ZERO};
	assign value_next = (value_q << 3) + (value_q << 1) + digit;
	assign chk_next   = (chk_q << 3) + (chk_q << 1) + digit;
	assign mismatch   = (chk_next != sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
		end else if (ctl.clear) begin
			value_q <= '0;
			sum_q   <= '0;
			chk_q   <= '0;
		end else begin
			if (ctl.data_en) begin
				value_q <= value_next;
				sum_q   <= sum_q + digit;
			end
			if (ctl.check_en) begin
				chk_q <= chk_next;
			end
		end
	end

	assign value_acc = value_q;
	assign sum_acc   = sum_q;

endmodule

@@ rtl/core/afp_ctrl.sv @@
module afp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	input  logic               mismatch,
	output afp_pkg::acc_ctl_t  acc_ctl,
	output afp_pkg::emit_t     emit,
	output logic [15:0]        func_q,
	output logic [6:0]         length_q
);
	import afp_pkg::*;

	phase_t      phase_q;
	phase_t      phase_d;
	logic [6:0]  cnt_q;
	logic [6:0]  cnt_d;
	logic [6:0]  cnt_inc;
	logic [6:0]  len_d;
	logic [6:0]  len_next;
	logic [15:0] func_d;
	logic        bad_end_q;
	logic        bad_end_d;
	logic        is_digit;
	logic [10:0] len_wide;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign cnt_inc  = cnt_q + 7'd1;
	assign len_wide = ({4'd0, length_q} << 3) + ({4'd0, length_q} << 1)
		+ {3'd0, rx_byte - CH_ZERO};
	assign len_next = len_wide[6:0];

	// next state
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		len_d     = length_q;
		func_d    = func_q;
		bad_end_d = bad_end_q;
		unique case (phase_q)
			PH_IDLE: begin
				cnt_d = '0;
				if (rx_byte == CH_START) begin
					phase_d = PH_FUNC;
					len_d   = '0;
					func_d  = '0;
				end
			end
			PH_FUNC: begin
				if (cnt_q == 7'd0) begin
					func_d = {rx_byte, 8'd0};
					cnt_d  = 7'd1;
				end else begin
					func_d  = {func_q[15:8], rx_byte};
					cnt_d   = '0;
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (!is_digit) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
				end else begin
					len_d = len_next;
					cnt_d = cnt_inc;
					if (cnt_inc >= 7'(LEN_DIGITS)) begin
						cnt_d   = '0;
						phase_d = (len_next == 7'd0) ? PH_CHECK : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= length_q) begin
					cnt_d   = '0;
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= 7'(CHECK_DIGITS)) begin
					cnt_d   = '0;
					phase_d = mismatch ? PH_IDLE : PH_END;
				end
			end
			PH_END: begin
				if (cnt_q == 7'd0) begin
					bad_end_d = (rx_byte != CH_LF);
					cnt_d     = 7'd1;
				end else begin
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// outputs
	always_comb begin
		acc_ctl.clear    = step && (phase_q == PH_IDLE) && (rx_byte == CH_START);
		acc_ctl.data_en  = step && (phase_q == PH_DATA);
		acc_ctl.check_en = step && (phase_q == PH_CHECK);
		emit.valid     = 1'b0;
		emit.status    = ST_OK;
		emit.zero_meta = 1'b0;
		emit.zero_data = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (rx_byte != CH_START) begin
					emit.valid     = 1'b1;
					emit.status    = ST_NOSTART;
					emit.zero_meta = 1'b1;
					emit.zero_data = 1'b1;
				end
			end
			PH_LEN: begin
				if (!is_digit) begin
					emit.valid     = 1'b1;
					emit.status    = ST_BADLEN;
					emit.zero_data = 1'b1;
				end
			end
			PH_CHECK: begin
				if (cnt_inc >= 7'(CHECK_DIGITS) && mismatch) begin
					emit.valid  = 1'b1;
					emit.status = ST_CHECKSUM;
				end
			end
			PH_END: begin
				if (cnt_q != 7'd0) begin
					emit.valid  = 1'b1;
					emit.status = (bad_end_q || rx_byte != CH_CR) ? ST_NOSTOP : ST_OK;
				end
			end
			default: begin
				emit.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			cnt_q     <= '0;
			length_q  <= '0;
			func_q    <= '0;
			bad_end_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			length_q  <= len_d;
			func_q    <= func_d;
			bad_end_q <= bad_end_d;
		end
	end

endmodule

@@ test/afp_frame_checker.sv @@
module afp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] func_code,
	input  logic [6:0]  data_length,
	input  logic [31:0] data_value,
	input  logic [31:0] sum_computed,
	output int          pending_results,
	output int          failures
);
	import afp_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [15:0] func_code;
		logic [6:0]  data_length;
		logic [31:0] data_value;
		logic [31:0] sum_computed;
	} frame_status_t;

	phase_t        phase;
	logic [6:0]    field_cnt;
	logic [6:0]    length_val;
	logic [15:0]   func_val;
	logic [31:0]   value_acc;
	logic [31:0]   digit_sum;
	logic [31:0]   check_acc;
	frame_status_t awaited_status[$];
	int            mismatches = 0;

	// Advance the frame parser by one byte; return 1 when the byte yields a status.
	function automatic bit parse_byte(input logic [7:0] b, output frame_status_t res);
		logic [31:0] digit;
		logic [31:0] len_next;
		digit = {24'd0, b} - {24'd0, CH_ZERO};
		res = '{ST_OK, func_val, length_val, value_acc, digit_sum};
		parse_byte = 1'b0;
		case (phase)
			PH_IDLE: begin
				if (b != CH_START) begin
					res = '{ST_NOSTART, 16'd0, 7'd0, 32'd0, 32'd0};
					parse_byte = 1'b1;
				end else begin
					phase = PH_FUNC;
					field_cnt = '0;
					length_val = '0;
					func_val = '0;
					value_acc = '0;
					digit_sum = '0;
					check_acc = '0;
				end
			end
			PH_FUNC: begin
				if (field_cnt == 0) begin
					func_val = {b, 8'h00};
					field_cnt = 7'd1;
				end else begin
					func_val[7:0] = b;
					field_cnt = '0;
					phase = PH_LEN;
				end
			end
			PH_LEN: begin
				if (b < CH_ZERO || b > CH_NINE) begin
					res.status = ST_BADLEN;
					res.data_value = '0;
					res.sum_computed = '0;
					parse_byte = 1'b1;
				end else begin
					len_next = {25'd0, length_val} * 32'd10 + digit;
					length_val = len_next[6:0];
					field_cnt = field_cnt + 7'd1;
					if (field_cnt >= LEN_DIGITS) begin
						field_cnt = '0;
						phase = (length_val == 0) ? PH_CHECK : PH_DATA;
					end
				end
			end
			PH_DATA: begin
				value_acc = value_acc * 32'd10 + digit;
				digit_sum = digit_sum + digit;
				field_cnt = field_cnt + 7'd1;
				if (field_cnt >= length_val) begin
					field_cnt = '0;
					phase = PH_CHECK;
				end
			end
			PH_CHECK: begin
				check_acc = check_acc * 32'd10 + digit;
				field_cnt = field_cnt + 7'd1;
				if (field_cnt >= CHECK_DIGITS) begin
					field_cnt = '0;
					if (check_acc != digit_sum) begin
						res.status = ST_CHECKSUM;
						parse_byte = 1'b1;
					end else begin
						// reuse as the bad-first-end-byte flag
						check_acc = '0;
						phase = PH_END;
					end
				end
			end
			PH_END: begin
				if (field_cnt == 0) begin
					check_acc = {31'd0, b != CH_LF};
					field_cnt = 7'd1;
				end else begin
					res.status = (check_acc != 0 || b != CH_CR) ? ST_NOSTOP : ST_OK;
					parse_byte = 1'b1;
				end
			end
			default: begin
				phase = PH_IDLE;
				field_cnt = '0;
			end
		endcase
		if (parse_byte) begin
			phase = PH_IDLE;
			field_cnt = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_status_t want;
		frame_status_t predicted;
		if (!arst_n) begin
			phase = PH_IDLE;
			field_cnt = '0;
			length_val = '0;
			func_val = '0;
			value_acc = '0;
			digit_sum = '0;
			check_acc = '0;
			awaited_status.delete();
			pending_results <= 0;
			failures <= 0;
		end else begin
			// a result is registered after its byte is taken: check before predicting
			if (out_valid && !out_stall) begin
				if (awaited_status.size() == 0) begin
					$error("status: no result expected, got %0d", status);
					mismatches++;
				end else begin
					want = awaited_status.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (func_code !== want.func_code) begin
						$error("func_code: expected %h, got %h", want.func_code, func_code);
						mismatches++;
					end
					if (data_length !== want.data_length) begin
						$error("data_length: expected %0d, got %0d",
							want.data_length, data_length);
						mismatches++;
					end
					if (data_value !== want.data_value) begin
						$error("data_value: expected %h, got %h", want.data_value, data_value);
						mismatches++;
					end
					if (sum_computed !== want.sum_computed) begin
						$error("sum_computed: expected %h, got %h",
							want.sum_computed, sum_computed);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(rx_byte, predicted))
					awaited_status.push_back(predicted);
			end
			pending_results <= awaited_status.size();
			failures <= mismatches;
		end
	end

endmodule

@@ test/tb_ascii_frame_parser.sv @@
module tb_ascii_frame_parser;
	import afp_pkg::*;

	// Total byte budget for the run, split over four idling phases.
	localparam int TOTAL_BYTES = 1700;
	// Length of the receiver hold-off that backs the parser up to its input.
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] func_code;
	logic [6:0]  data_length;
	logic [31:0] data_value;
	logic [31:0] sum_computed;

	int          pending_results;
	int          failures;

	// Per-cycle odds (out of 100) of a sender gap and of a receiver stall.
	int          sender_idle_pct = 0;
	int          receiver_stall_pct = 0;
	logic        hold_active = 1'b0;
	event        begin_hold;

	// Bytes lined up for the sender, and how many have been transferred so far.
	logic [7:0]  byte_q[$];
	int          bytes_sent = 0;

	ascii_frame_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.func_code    (func_code),
		.data_length  (data_length),
		.data_value   (data_value),
		.sum_computed (sum_computed)
	);

	afp_frame_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.func_code       (func_code),
		.data_length     (data_length),
		.data_value      (data_value),
		.sum_computed    (sum_computed),
		.pending_results (pending_results),
		.failures        (failures)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver: stall at random, or solidly while a hold-off is running.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_active || ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Hold-off: count its own cycles so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(begin_hold);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	// Drain byte_q through the input channel. Valid is only dropped for a
	// sender gap, never between two back-to-back transfers, and the payload
	// holds while stalled.
	task automatic send_queued();
		while (byte_q.size() != 0) begin
			while ($urandom_range(99) < sender_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			rx_byte  <= byte_q.pop_front();
			@(posedge clk);
			while (in_stall) @(posedge clk);
			bytes_sent++;
		end
	endtask

	// Line up one frame with random content. Most lengths are short, a few
	// reach the top of the length field so the value accumulator wraps.
	// Data bytes are mostly digits; the checksum usually matches (it is
	// solved for with possibly non-digit check bytes) and the end bytes are
	// usually LF then CR.
	task automatic queue_frame();
		int unsigned n;
		int unsigned pick;
		int          sum;
		int          rem;
		int          tens;
		logic [7:0]  b;
		logic [15:0] fc;
		fc = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 85)
			n = $urandom_range(12);
		else if (pick < 97)
			n = $urandom_range(40, 13);
		else
			n = $urandom_range(99, 90);
		byte_q.push_back(CH_START);
		byte_q.push_back(fc[15:8]);
		byte_q.push_back(fc[7:0]);
		byte_q.push_back(8'(CH_ZERO + n / 10));
		byte_q.push_back(8'(CH_ZERO + n % 10));
		sum = 0;
		repeat (n) begin
			if ($urandom_range(99) < 85)
				b = 8'(CH_ZERO + $urandom_range(9));
			else
				b = 8'($urandom_range(255));
			sum += int'(b) - int'(CH_ZERO);
			byte_q.push_back(b);
		end
		// split the digit sum into tens and units check digits
		rem = sum % 10;
		if (rem < 0)
			rem += 10;
		tens = (sum - rem) / 10;
		if ($urandom_range(99) < 80 && tens >= -int'(CH_ZERO) && tens <= 255 - int'(CH_ZERO)) begin
			byte_q.push_back(8'(tens + int'(CH_ZERO)));
			byte_q.push_back(8'(rem + int'(CH_ZERO)));
		end else if ($urandom_range(99) < 90) begin
			byte_q.push_back(8'(CH_ZERO + $urandom_range(9)));
			byte_q.push_back(8'(CH_ZERO + $urandom_range(9)));
		end else begin
			byte_q.push_back(8'($urandom_range(255)));
			byte_q.push_back(8'($urandom_range(255)));
		end
		pick = $urandom_range(99);
		if (pick < 85) begin
			byte_q.push_back(CH_LF);
			byte_q.push_back(CH_CR);
		end else if (pick < 90) begin
			byte_q.push_back(CH_CR);
			byte_q.push_back(CH_LF);
		end else if (pick < 95) begin
			byte_q.push_back(CH_LF);
			byte_q.push_back(8'($urandom_range(255)));
		end else begin
			byte_q.push_back(8'($urandom_range(255)));
			byte_q.push_back(CH_CR);
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned cut;
		logic [7:0]  b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, no idling on either side.
		byte_q = '{
			// no start from idle, at both byte extremes
			8'h00, 8'hFF,
			// zero length skips the data phase; matching checksum, clean end
			CH_START, 8'h00, 8'h00, "0", "0", "0", "0", CH_LF, CH_CR,
			// all-ones function code, non-digit data at both extremes, checksum
			// matched through a non-digit check byte, end bytes swapped
			CH_START, 8'hFF, 8'hFF, "0", "2", 8'h00, 8'hFF, "?", "9", CH_CR, CH_LF,
			// bad length on the first digit, then on the second
			CH_START, 8'h12, 8'h34, "/",
			CH_START, 8'h56, 8'h78, "9", ":",
			// checksum mismatch reports without waiting for end bytes
			CH_START, "A", "B", "0", "1", "7", "0", "8"
		};
		send_queued();

		// Random part: well-formed frames mostly, mixed with stray bytes, frames
		// broken in the length field and frames cut short.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 45;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 45;
				end
				default: begin
					sender_idle_pct = 36;
					receiver_stall_pct = 36;
				end
			endcase
			if (p == 0) begin
				// Hold the result side off and keep offering bytes: each stray
				// byte yields a status, so the parser backs up and stalls input.
				-> begin_hold;
				repeat (24) begin
					b = 8'($urandom_range(255));
					if (b == CH_START)
						b = 8'h00;
					byte_q.push_back(b);
				end
				repeat (4) queue_frame();
				send_queued();
			end
			while (bytes_sent < (p + 1) * TOTAL_BYTES / 4) begin
				pick = $urandom_range(99);
				if (pick < 75) begin
					queue_frame();
				end else if (pick < 85) begin
					repeat ($urandom_range(3, 1)) byte_q.push_back(8'($urandom_range(255)));
				end else if (pick < 93) begin
					byte_q.push_back(CH_START);
					byte_q.push_back(8'($urandom_range(255)));
					byte_q.push_back(8'($urandom_range(255)));
					if ($urandom_range(1))
						byte_q.push_back(8'(CH_ZERO + $urandom_range(9)));
					do
						b = 8'($urandom_range(255));
					while (b >= CH_ZERO && b <= CH_NINE);
					byte_q.push_back(b);
				end else begin
					// drop the tail so the next bytes land mid-frame
					queue_frame();
					cut = $urandom_range(byte_q.size() - 1, 1);
					repeat (cut) void'(byte_q.pop_back());
				end
				send_queued();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		// give a stray late result time to show up
		repeat (16) @(posedge clk);
		if (failures == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(12 * 600000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/afp_pkg.sv
rtl/core/afp_acc.sv
rtl/core/afp_ctrl.sv
rtl/core/ascii_frame_parser.sv
test/afp_frame_checker.sv
test/tb_ascii_frame_parser.sv
